/* rtl/velocity_moment_accumulator_defines.svh */
// Assertion macros for the velocity moment accumulator checker.
// Needs clk and rst_n in scope at the place of use.
`ifndef VELOCITY_MOMENT_ACCUMULATOR_DEFINES_SVH
`define VELOCITY_MOMENT_ACCUMULATOR_DEFINES_SVH

// same-cycle implication
`define VMA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/vma_pkg.sv */
// Shared types and constants for the velocity moment accumulator.
// No dependencies.
`default_nettype none

package vma_pkg;

    localparam int MAX_PARTICLES = 65536;
    localparam int FRAC_BITS     = 16;
    localparam int VEL_WIDTH     = 24;

    localparam int W_COUNT  = 17;
    localparam int W_FIRST  = 40;
    localparam int W_SECOND = 47;
    localparam int W_THIRD  = 56;
    localparam int W_TOTAL  = 48;

    // square of a component, floored: nonnegative, top value 2^(SQ_W-1)
    localparam int SQ_PROD_W   = 2 * VEL_WIDTH;
    localparam int SQ_W        = SQ_PROD_W - 1 - FRAC_BITS;
    localparam int SPD_W       = SQ_W + 1;
    localparam int FLUX_PROD_W = VEL_WIDTH + SPD_W + 1;
    localparam int FLUX_W      = FLUX_PROD_W - FRAC_BITS;

    localparam logic [W_COUNT-1:0] COUNT_MAX = W_COUNT'(MAX_PARTICLES);

    typedef struct packed {
        logic signed [VEL_WIDTH-1:0] vel_x;
        logic signed [VEL_WIDTH-1:0] vel_y;
        logic signed [VEL_WIDTH-1:0] vel_z;
        logic                        no_particle;
        logic                        last;
    } vma_item_t;

    typedef struct packed {
        logic        [W_COUNT-1:0]  particle_count;
        logic signed [W_FIRST-1:0]  sum_vx;
        logic signed [W_FIRST-1:0]  sum_vy;
        logic signed [W_FIRST-1:0]  sum_vz;
        logic        [W_SECOND-1:0] sum_sq_x;
        logic        [W_SECOND-1:0] sum_sq_y;
        logic        [W_SECOND-1:0] sum_sq_z;
        logic signed [W_THIRD-1:0]  sum_flux_x;
        logic signed [W_THIRD-1:0]  sum_flux_y;
        logic signed [W_THIRD-1:0]  sum_flux_z;
        logic        [W_TOTAL-1:0]  sum_sq_total;
        logic                       overflow;
    } vma_result_t;

    typedef struct packed {
        logic load;
        logic square;
        logic speed;
        logic flux;
        logic accum;
        logic emit;
    } vma_cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } vma_status_t;

endpackage

`default_nettype wire

/* rtl/vma_ctrl.sv */
// Sequencer for the velocity moment accumulator.
// Depends on vma_pkg; drives vma_datapath through vma_cmd_t.
`default_nettype none

module vma_ctrl
    import vma_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    input  wire logic        item_no_particle,
    input  wire logic        item_last,
    input  wire vma_status_t status,
    output logic             item_stall,
    output vma_cmd_t         cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SQ    = 6'b000010,
        S_SPEED = 6'b000100,
        S_FLUX  = 6'b001000,
        S_ACC   = 6'b010000,
        S_EMIT  = 6'b100000
    } vma_state_t;

    vma_state_t state_reg;
    vma_state_t state_next;
    logic       accept;

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    if (!item_no_particle)
                        state_next = S_SQ;
                    else if (item_last)
                        state_next = S_EMIT;
                end
            end
            S_SQ:
            begin
                cmd.square = 1'b1;
                state_next = S_SPEED;
            end
            S_SPEED:
            begin
                cmd.speed  = 1'b1;
                state_next = S_FLUX;
            end
            S_FLUX:
            begin
                cmd.flux   = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.accum  = 1'b1;
                state_next = status.last ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

/* rtl/vma_datapath.sv */
// Multipliers, accumulators and output register of the velocity moment accumulator.
// Depends on vma_pkg; sequenced by vma_ctrl.
`default_nettype none

module vma_datapath
    import vma_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire vma_item_t   item,
    input  wire vma_cmd_t    cmd,
    input  wire logic        result_stall,
    output vma_status_t      status,
    output logic             result_valid,
    output vma_result_t      result
);

    logic signed [VEL_WIDTH-1:0]   vel_reg [3];
    logic                          last_reg;
    logic        [SQ_W-1:0]        sq_reg [3];
    logic        [SPD_W-1:0]       speed_reg;
    logic signed [FLUX_W-1:0]      flux_reg [3];

    logic        [W_COUNT-1:0]     count_reg;
    logic signed [W_FIRST-1:0]     first_reg [3];
    logic        [W_SECOND-1:0]    second_reg [3];
    logic signed [W_THIRD-1:0]     third_reg [3];
    logic                          ovf_reg;
    logic                          out_valid_reg;
    vma_result_t                   out_reg;

    logic signed [SQ_PROD_W-1:0]   sq_prod [3];
    logic signed [FLUX_PROD_W-1:0] flux_prod [3];
    logic        [W_TOTAL-1:0]     total;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_prod[i]   = vel_reg[i] * vel_reg[i];
            flux_prod[i] = vel_reg[i] * $signed({1'b0, speed_reg});
        end
    end

    assign total = {1'b0, second_reg[0]} + {1'b0, second_reg[1]} + {1'b0, second_reg[2]};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            vel_reg[0] <= item.vel_x;
            vel_reg[1] <= item.vel_y;
            vel_reg[2] <= item.vel_z;
            last_reg   <= item.last;
        end
        // floor by dropping fraction bits; squares are never negative
        if (cmd.square)
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= sq_prod[i][SQ_W+FRAC_BITS-1:FRAC_BITS];
        if (cmd.speed)
            speed_reg <= {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]} + {1'b0, sq_reg[2]};
        if (cmd.flux)
            for (int i = 0; i < 3; i++)
                flux_reg[i] <= flux_prod[i][FLUX_PROD_W-1:FRAC_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                first_reg[i]  <= '0;
                second_reg[i] <= '0;
                third_reg[i]  <= '0;
            end
        end
        else if (cmd.emit)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                first_reg[i]  <= '0;
                second_reg[i] <= '0;
                third_reg[i]  <= '0;
            end
        end
        else if (cmd.accum)
        begin
            if (count_reg >= COUNT_MAX)
                ovf_reg <= 1'b1;
            else
            begin
                count_reg <= count_reg + 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    first_reg[i]  <= first_reg[i]
                        + {{(W_FIRST-VEL_WIDTH){vel_reg[i][VEL_WIDTH-1]}}, vel_reg[i]};
                    second_reg[i] <= second_reg[i] + {{(W_SECOND-SQ_W){1'b0}}, sq_reg[i]};
                    third_reg[i]  <= third_reg[i]
                        + {{(W_THIRD-FLUX_W){flux_reg[i][FLUX_W-1]}}, flux_reg[i]};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.particle_count <= count_reg;
            out_reg.sum_vx         <= first_reg[0];
            out_reg.sum_vy         <= first_reg[1];
            out_reg.sum_vz         <= first_reg[2];
            out_reg.sum_sq_x       <= second_reg[0];
            out_reg.sum_sq_y       <= second_reg[1];
            out_reg.sum_sq_z       <= second_reg[2];
            out_reg.sum_flux_x     <= third_reg[0];
            out_reg.sum_flux_y     <= third_reg[1];
            out_reg.sum_flux_z     <= third_reg[2];
            out_reg.sum_sq_total   <= total;
            out_reg.overflow       <= ovf_reg;
        end
    end

    assign status.last     = last_reg;
    assign status.out_free = !out_valid_reg || !result_stall;
    assign result_valid    = out_valid_reg;
    assign result          = out_reg;

endmodule

`default_nettype wire

/* rtl/velocity_moment_accumulator.sv */
// Top level of the velocity moment accumulator: vma_ctrl plus vma_datapath.
// Depends on vma_pkg, vma_ctrl, vma_datapath.
//
// One item is taken at a time. A particle beat occupies the block through
// accept, square, speed sum, flux multiply and accumulate; a beat with no
// particle ends at its accept. A beat marked last adds an emit step to move
// the sums into the output register and clear the accumulators; that step
// waits while an earlier result is still stalled at the output. The
// registered squaring, speed sum and flux multiply set the sequence length.
`default_nettype none

module velocity_moment_accumulator
    import vma_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_stall,
    input  wire vma_item_t item,
    output logic           result_valid,
    input  wire logic      result_stall,
    output vma_result_t    result
);

    vma_cmd_t    cmd;
    vma_status_t status;

    vma_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_no_particle (item.no_particle),
        .item_last        (item.last),
        .status           (status),
        .item_stall       (item_stall),
        .cmd              (cmd)
    );

    vma_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .result_stall (result_stall),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

/* rtl/vma_checker.sv */
// Port-level checks for velocity_moment_accumulator, attached by bind.
// Depends on vma_pkg and velocity_moment_accumulator_defines.svh.
`default_nettype none

`include "velocity_moment_accumulator_defines.svh"

module vma_checker
    import vma_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        item_valid,
    input wire logic        item_stall,
    input wire vma_item_t   item,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire vma_result_t result
);

    logic accept;
    assign accept = item_valid && !item_stall;

    `VMA_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
        result_valid && $stable(result), "stalled result beat changed")
    `VMA_ASSERT_NEXT(a_busy_after_particle, accept && !item.no_particle,
        item_stall, "particle beat did not occupy the block")
    `VMA_ASSERT_NEXT(a_free_after_empty, accept && item.no_particle && !item.last,
        !item_stall, "empty beat held the input")
    `VMA_ASSERT_NOW(a_count_range, result_valid,
        result.particle_count <= COUNT_MAX, "particle count above capacity")
    `VMA_ASSERT_NOW(a_overflow_full, result_valid && result.overflow,
        result.particle_count == COUNT_MAX, "overflow without full count")

endmodule

bind velocity_moment_accumulator vma_checker u_vma_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

/* verif/moment_scoreboard_pkg.sv */
// Scoreboard for the velocity moment accumulator: predicts each run's moments.
// Depends on vma_pkg for the beat and result types and the sum widths.
`timescale 1ns / 1ps

package moment_scoreboard_pkg;
    import vma_pkg::*;

    class moment_scoreboard;
        logic [W_COUNT-1:0]  count_sum;
        logic [W_FIRST-1:0]  vel_sum [3];
        logic [W_SECOND-1:0] sq_sum [3];
        logic [W_THIRD-1:0]  flux_sum [3];
        logic                capped;
        vma_result_t         moments_q [$];
        int                  mismatches;
        int                  runs_checked;
        int                  capped_runs;

        function new();
            clear_sums();
            mismatches   = 0;
            runs_checked = 0;
            capped_runs  = 0;
        endfunction

        function void clear_sums();
            count_sum = '0;
            capped    = 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                vel_sum[i]  = '0;
                sq_sum[i]   = '0;
                flux_sum[i] = '0;
            end
        endfunction

        function int outstanding();
            return moments_q.size();
        endfunction

        // accepted input beat
        function void take_beat(vma_item_t beat);
            longint      v [3];
            longint      sq [3];
            longint      speed2;
            vma_result_t r;
            if (!beat.no_particle)
            begin
                if (count_sum >= COUNT_MAX)
                    capped = 1'b1;
                else
                begin
                    v[0]   = longint'($signed(beat.vel_x));
                    v[1]   = longint'($signed(beat.vel_y));
                    v[2]   = longint'($signed(beat.vel_z));
                    speed2 = 0;
                    for (int i = 0; i < 3; i++)
                    begin
                        sq[i]  = (v[i] * v[i]) >>> FRAC_BITS;
                        speed2 = speed2 + sq[i];
                    end
                    for (int i = 0; i < 3; i++)
                    begin
                        vel_sum[i]  = vel_sum[i] + W_FIRST'(v[i]);
                        sq_sum[i]   = sq_sum[i] + W_SECOND'(sq[i]);
                        flux_sum[i] = flux_sum[i] + W_THIRD'((v[i] * speed2) >>> FRAC_BITS);
                    end
                    count_sum = count_sum + 1'b1;
                end
            end
            if (beat.last)
            begin
                r.particle_count = count_sum;
                r.sum_vx         = vel_sum[0];
                r.sum_vy         = vel_sum[1];
                r.sum_vz         = vel_sum[2];
                r.sum_sq_x       = sq_sum[0];
                r.sum_sq_y       = sq_sum[1];
                r.sum_sq_z       = sq_sum[2];
                r.sum_flux_x     = flux_sum[0];
                r.sum_flux_y     = flux_sum[1];
                r.sum_flux_z     = flux_sum[2];
                r.sum_sq_total   = W_TOTAL'(sq_sum[0]) + W_TOTAL'(sq_sum[1])
                                 + W_TOTAL'(sq_sum[2]);
                r.overflow       = capped;
                moments_q.insert(moments_q.size(), r);
                clear_sums();
            end
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                mismatches++;
                $display("%0t: %s expected %h, got %h", $time, name, want, got);
            end
        endfunction

        // accepted result beat
        function void check_moments(vma_result_t got);
            vma_result_t want;
            if (moments_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: result beat expected none, got %h", $time, got);
                return;
            end
            want = moments_q.pop_front();
            runs_checked++;
            if (want.overflow)
                capped_runs++;
            compare_field("particle_count", want.particle_count, got.particle_count);
            compare_field("sum_vx", want.sum_vx, got.sum_vx);
            compare_field("sum_vy", want.sum_vy, got.sum_vy);
            compare_field("sum_vz", want.sum_vz, got.sum_vz);
            compare_field("sum_sq_x", want.sum_sq_x, got.sum_sq_x);
            compare_field("sum_sq_y", want.sum_sq_y, got.sum_sq_y);
            compare_field("sum_sq_z", want.sum_sq_z, got.sum_sq_z);
            compare_field("sum_flux_x", want.sum_flux_x, got.sum_flux_x);
            compare_field("sum_flux_y", want.sum_flux_y, got.sum_flux_y);
            compare_field("sum_flux_z", want.sum_flux_z, got.sum_flux_z);
            compare_field("sum_sq_total", want.sum_sq_total, got.sum_sq_total);
            compare_field("overflow", want.overflow, got.overflow);
        endfunction
    endclass

endpackage

/* verif/tb_top.sv */
// Top testbench for velocity_moment_accumulator: drives particle runs, checks moments.
// Depends on vma_pkg, moment_scoreboard_pkg and the accumulator RTL.
`timescale 1ns / 1ps

module tb_top;
    import vma_pkg::*;
    import moment_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_stall;
    vma_item_t   item         = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    vma_result_t result;

    moment_scoreboard sb;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit pressure_armed = 1'b0;
    int hold_left      = 0;
    int cycles         = 0;
    int beats_sent     = 0;
    int in_stall_cycles = 0;

    velocity_moment_accumulator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [VEL_WIDTH-1:0] rand_vel();
        case ($urandom_range(9))
            0:       return {1'b0, {(VEL_WIDTH-1){1'b1}}};
            1:       return {1'b1, {(VEL_WIDTH-1){1'b0}}};
            2:       return VEL_WIDTH'(int'($urandom_range(512)) - 256);
            3:       return '0;
            default: return VEL_WIDTH'($urandom);
        endcase
    endfunction

    function automatic vma_item_t make_beat(logic [VEL_WIDTH-1:0] vx, logic [VEL_WIDTH-1:0] vy,
                                            logic [VEL_WIDTH-1:0] vz, logic np, logic lst);
        vma_item_t b;
        b.vel_x       = vx;
        b.vel_y       = vy;
        b.vel_z       = vz;
        b.no_particle = np;
        b.last        = lst;
        return b;
    endfunction

    task automatic send_beat(input vma_item_t beat);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item       <= beat;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        sb.take_beat(beat);
        beats_sent++;
    endtask

    task automatic random_runs(input int beats, input int longest);
        int sent;
        int len;
        int short_cap;
        bit close_empty;
        sent      = 0;
        short_cap = (longest < 6) ? longest : 6;
        while (sent < beats)
        begin
            if ($urandom_range(99) < 8)
            begin
                send_beat(make_beat(rand_vel(), rand_vel(), rand_vel(), 1'b1, 1'b1));
                sent++;
            end
            else
            begin
                if ($urandom_range(9) == 0)
                    len = int'($urandom_range(longest, 1));
                else
                    len = int'($urandom_range(short_cap, 1));
                close_empty = ($urandom_range(4) == 0);
                for (int j = 0; j < len; j++)
                begin
                    if ($urandom_range(11) == 0)
                        send_beat(make_beat(rand_vel(), rand_vel(), rand_vel(), 1'b1, 1'b0));
                    send_beat(make_beat(rand_vel(), rand_vel(), rand_vel(), 1'b0,
                                        !close_empty && (j == len - 1)));
                    sent++;
                end
                if (close_empty)
                begin
                    send_beat(make_beat(rand_vel(), rand_vel(), rand_vel(), 1'b1, 1'b1));
                    sent++;
                end
            end
        end
    endtask

    // result side backpressure; a long hold can be armed from the stimulus
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else if (pressure_armed)
            begin
                pressure_armed = 1'b0;
                hold_left      = HOLD_CYCLES - 1;
                result_stall   <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_moments(result);
        if (rst_n && item_valid && item_stall)
            in_stall_cycles++;
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.outstanding());
            $display("** velocity_moment_accumulator: FAILED **");
            $finish;
        end
    end

    localparam logic [VEL_WIDTH-1:0] VMAX = {1'b0, {(VEL_WIDTH-1){1'b1}}};
    localparam logic [VEL_WIDTH-1:0] VMIN = {1'b1, {(VEL_WIDTH-1){1'b0}}};

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty run, ignored beat, extremes, floor of small products
        send_beat(make_beat(VMAX, VMIN, VMAX, 1'b1, 1'b1));
        send_beat(make_beat(VMIN, VMAX, VMIN, 1'b1, 1'b0));
        send_beat(make_beat(VMAX, VMAX, VMAX, 1'b0, 1'b0));
        send_beat(make_beat(VMIN, VMIN, VMIN, 1'b0, 1'b0));
        send_beat(make_beat(-24'sd1, 24'sd256, 24'sd0, 1'b0, 1'b0));
        send_beat(make_beat(24'sd1, -24'sd1, VMIN, 1'b0, 1'b1));
        send_beat(make_beat(VMIN, VMAX, 24'sd0, 1'b0, 1'b1));
        send_beat(make_beat(24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0));
        send_beat(make_beat(VMAX, VMAX, VMAX, 1'b1, 1'b1));
        send_beat(make_beat(VMAX, 24'sd0, -24'sd256, 1'b0, 1'b0));
        send_beat(make_beat(VMIN, VMIN, VMIN, 1'b1, 1'b0));
        send_beat(make_beat(-24'sd2, -24'sd3, -24'sd65536, 1'b0, 1'b1));
        send_beat(make_beat(-24'sd1, -24'sd1, -24'sd1, 1'b0, 1'b1));
        send_beat(make_beat(24'sd0, 24'sd0, 24'sd0, 1'b1, 1'b1));

        random_runs(230, 40);
        send_idle_pct = 69;
        random_runs(230, 40);
        send_idle_pct  = 0;
        recv_stall_pct = 69;
        random_runs(230, 40);
        send_idle_pct  = 21;
        recv_stall_pct = 21;
        random_runs(230, 40);

        // long output hold with back-to-back short runs
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pressure_armed = 1'b1;
        random_runs(60, 2);

        @(negedge clk);
        item_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d beats sent, %0d runs checked (%0d past capacity), input stalled %0d cycles",
                 beats_sent, sb.runs_checked, sb.capped_runs, in_stall_cycles);
        $display("covered extremes, empty and no-particle closes, idle and stall mixes, long hold");
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("** velocity_moment_accumulator: PASSED **");
        else
            $display("** velocity_moment_accumulator: FAILED **");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/vma_pkg.sv
rtl/vma_ctrl.sv
rtl/vma_datapath.sv
rtl/velocity_moment_accumulator.sv
rtl/vma_checker.sv
verif/moment_scoreboard_pkg.sv
verif/tb_top.sv
